@@ hw/rtl/fscb_pkg.sv @@
package fscb_pkg;

	localparam int MAX_FACES_DEF = 1048576;
	localparam int FRAC_BITS_DEF = 16;
	localparam int SF_W          = 17;
	localparam int VI_W          = 22;

	localparam logic [SF_W-1:0] SF_ONE = 17'h10000;

	localparam logic [2:0] MASK_ALL = 3'b111;
	localparam logic [2:0] MASK_NO1 = 3'b110;
	localparam logic [2:0] MASK_NO2 = 3'b101;
	localparam logic [2:0] MASK_NO3 = 3'b011;

	localparam logic [1:0] MODE_POS    = 2'd0;
	localparam logic [1:0] MODE_BITAN  = 2'd3;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] c1_x;
		logic signed [31:0] c1_y;
		logic signed [31:0] c1_z;
		logic signed [31:0] c2_x;
		logic signed [31:0] c2_y;
		logic signed [31:0] c2_z;
		logic signed [31:0] c3_x;
		logic signed [31:0] c3_y;
		logic signed [31:0] c3_z;
	} fscb_in_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [VI_W-1:0]    vertex_index;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               last;
	} fscb_out_t;

	typedef struct packed {
		logic       load;
		logic       dot;
		logic       cmp;
		logic       sum;
		logic       norm;
		logic       sq;
		logic       root;
		logic       div_init;
		logic       div_step;
		logic       div_store;
		logic       lerp;
		logic       out_load;
		logic       face_inc;
		logic [4:0] idx;
		logic [1:0] sel;
	} fscb_cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       mx_zero;
		logic       mx_high;
		logic       mx_low;
	} fscb_stat_t;

endpackage

@@ hw/rtl/fscb_if.sv @@
interface fscb_in_if import fscb_pkg::*;;
	logic     valid;
	logic     ready;
	fscb_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fscb_out_if import fscb_pkg::*;;
	logic      valid;
	logic      ready;
	fscb_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/fscb_dp.sv @@
module fscb_dp import fscb_pkg::*; #(
	parameter int MAX_FACES = MAX_FACES_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  fscb_in_t        in_data,
	input  logic            cfg_we,
	input  logic [SF_W-1:0] cfg_data,
	input  fscb_cmd_t       cmd,
	output fscb_stat_t      st,
	output fscb_out_t       out_data
);

	localparam int FCW   = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
	localparam int ACC_W = 72;
	localparam int QB    = FRAC_BITS + 1;
	localparam int DW    = 32 + FRAC_BITS;
	localparam int NW    = FRAC_BITS + 3;
	localparam logic signed [ACC_W-1:0] ONE_Q  = ACC_W'(1) << FRAC_BITS;
	localparam logic [ACC_W-1:0]        NEAR_Q = ACC_W'(((64'd1 << FRAC_BITS) * 2 + 5) / 10);
	localparam logic [FCW-1:0]          FC_LAST = FCW'(MAX_FACES - 1);

	logic [1:0]               mode_q;
	logic signed [31:0]       c_q [3][3];
	logic [SF_W-1:0]          sf_q;
	logic [SF_W-1:0]          sfl_q;
	logic [2:0]               mask_q;
	logic [FCW-1:0]           fc_q;
	logic signed [ACC_W-1:0]  prod_s1;
	logic [1:0]               grp_s1;
	logic                     vld_s1;
	logic signed [ACC_W-1:0]  a_q [3];
	logic [2:0]               sneg_q;
	logic [32:0]              m_q [3];
	logic [63:0]              sq_q;
	logic [63:0]              r_q;
	logic [DW-1:0]            rem_q;
	logic [QB-1:0]            q_q;
	logic signed [NW-1:0]     n_q [3];
	logic signed [31:0]       res_q [3];
	fscb_out_t                out_q;

	function automatic logic near_one(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] d;
		logic [ACC_W-1:0]        md;
		d  = a - ONE_Q;
		md = d[ACC_W-1] ? ACC_W'(-d) : ACC_W'(d);
		return md < NEAR_Q;
	endfunction

	// dot product operands
	logic [1:0]          grp, cj;
	logic signed [32:0]  e21, e31, e32, du, dv;
	logic                pneg;
	logic [32:0]         mu, mv;
	logic [65:0]         pm;
	logic [ACC_W-1:0]    pu;

	always_comb begin
		case (cmd.idx[3:0])
			4'd0: begin grp = 2'd0; cj = 2'd0; end
			4'd1: begin grp = 2'd0; cj = 2'd1; end
			4'd2: begin grp = 2'd0; cj = 2'd2; end
			4'd3: begin grp = 2'd1; cj = 2'd0; end
			4'd4: begin grp = 2'd1; cj = 2'd1; end
			4'd5: begin grp = 2'd1; cj = 2'd2; end
			4'd6: begin grp = 2'd2; cj = 2'd0; end
			4'd7: begin grp = 2'd2; cj = 2'd1; end
			4'd8: begin grp = 2'd2; cj = 2'd2; end
			default: begin grp = 2'd0; cj = 2'd0; end
		endcase
		e21 = 33'(c_q[1][cj]) - 33'(c_q[0][cj]);
		e31 = 33'(c_q[2][cj]) - 33'(c_q[0][cj]);
		e32 = 33'(c_q[2][cj]) - 33'(c_q[1][cj]);
		case (grp)
			2'd0: begin du = e21; dv = e31; pneg = (e21 < 0) ^ (e31 < 0); end
			2'd1: begin du = e21; dv = e32; pneg = (e21 > 0) ^ (e32 < 0); end
			default: begin du = e31; dv = e31; pneg = 1'b0; end
		endcase
		mu = du[32] ? 33'(-du) : 33'(du);
		mv = dv[32] ? 33'(-dv) : 33'(dv);
		pm = 66'(mu) * 66'(mv);
		pu = ACC_W'(pm >> FRAC_BITS);
	end

	// weighted sum
	logic signed [33:0] ws [3];
	logic [32:0]        mx;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			ws[j] = (mask_q[0] ? 34'(c_q[0][j]) : 34'sd0)
			      + (mask_q[1] ? 34'(c_q[1][j]) : 34'sd0)
			      + (mask_q[2] ? 34'(c_q[2][j]) : 34'sd0);
		end
		mx = m_q[0];
		if (m_q[1] > mx) mx = m_q[1];
		if (m_q[2] > mx) mx = m_q[2];
	end

	assign st.mode    = mode_q;
	assign st.mx_zero = (mx == 33'd0);
	assign st.mx_high = |mx[32:30];
	assign st.mx_low  = ~|mx[32:29];

	// root, divide, lerp
	logic [29:0]          msel;
	logic [63:0]          rbit, rt;
	logic [30:0]          len;
	logic [DW-1:0]        dvs;
	logic                 ge;
	logic signed [31:0]   la;
	logic signed [33:0]   ld;
	logic [33:0]          lmd;
	logic [51:0]          lp;
	logic signed [35:0]   lr;
	logic signed [35:0]   lres;

	always_comb begin
		msel = m_q[cmd.sel][29:0];
		rbit = 64'd1 << (62 - 2 * int'(cmd.idx));
		rt   = r_q + rbit;
		len  = r_q[30:0];
		dvs  = DW'(len) << ((QB - 1) - int'(cmd.idx));
		ge   = rem_q >= dvs;
		la   = c_q[cmd.sel][cmd.idx[1:0]];
		ld   = 34'(n_q[cmd.idx[1:0]]) - 34'(la);
		lmd  = ld[33] ? 34'(-ld) : 34'(ld);
		lp   = 52'(lmd) * 52'(sfl_q) + 52'd32768;
		lr   = ld[33] ? -36'(lp >> 16) : 36'(lp >> 16);
		lres = 36'(la) + lr;
	end

	logic [FCW+24:0] vidx;
	assign vidx = {25'd0, fc_q} + {24'd0, fc_q, 1'b0} + (FCW+25)'(cmd.sel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sf_q   <= '0;
			mask_q <= MASK_ALL;
			fc_q   <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (cfg_we) sf_q <= cfg_data;
			vld_s1 <= cmd.dot;
			if (cmd.cmp) begin
				if (near_one(a_q[0]))      mask_q <= MASK_NO1;
				else if (near_one(a_q[1])) mask_q <= MASK_NO2;
				else if (near_one(a_q[2])) mask_q <= MASK_NO3;
				else                       mask_q <= MASK_ALL;
			end
			if (cmd.face_inc) fc_q <= (fc_q == FC_LAST) ? '0 : fc_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= in_data.mode;
			c_q[0][0] <= in_data.c1_x; c_q[0][1] <= in_data.c1_y; c_q[0][2] <= in_data.c1_z;
			c_q[1][0] <= in_data.c2_x; c_q[1][1] <= in_data.c2_y; c_q[1][2] <= in_data.c2_z;
			c_q[2][0] <= in_data.c3_x; c_q[2][1] <= in_data.c3_y; c_q[2][2] <= in_data.c3_z;
			sfl_q   <= (sf_q > SF_ONE) ? SF_ONE : sf_q;
			for (int g = 0; g < 3; g++) a_q[g] <= '0;
		end
		if (cmd.dot) begin
			prod_s1 <= pneg ? -$signed(pu) : $signed(pu);
			grp_s1  <= grp;
		end
		if (vld_s1) a_q[grp_s1] <= a_q[grp_s1] + prod_s1;
		if (cmd.sum) begin
			for (int j = 0; j < 3; j++) begin
				sneg_q[j] <= ws[j][33];
				m_q[j]    <= ws[j][33] ? 33'(-ws[j]) : 33'(ws[j]);
				n_q[j]    <= '0;
			end
			sq_q <= '0;
			r_q  <= '0;
		end
		if (cmd.norm) begin
			for (int j = 0; j < 3; j++) begin
				if (st.mx_high)     m_q[j] <= m_q[j] >> 1;
				else if (st.mx_low) m_q[j] <= m_q[j] << 1;
			end
		end
		if (cmd.sq) sq_q <= sq_q + 64'(60'(msel) * 60'(msel));
		if (cmd.root) begin
			if (sq_q >= rt) begin
				sq_q <= sq_q - rt;
				r_q  <= (r_q >> 1) + rbit;
			end else begin
				r_q <= r_q >> 1;
			end
		end
		if (cmd.div_init) begin
			rem_q <= DW'({msel, FRAC_BITS'(0)}) + DW'(len >> 1);
			q_q   <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? rem_q - dvs : rem_q;
			q_q   <= {q_q[QB-2:0], ge};
		end
		if (cmd.div_store)
			n_q[cmd.sel] <= sneg_q[cmd.sel] ? -$signed({2'b00, q_q}) : $signed({2'b00, q_q});
		if (cmd.lerp) res_q[cmd.idx[1:0]] <= lres[31:0];
		if (cmd.out_load) begin
			out_q.kind         <= mode_q;
			out_q.vertex_index <= vidx[VI_W-1:0];
			out_q.last         <= (cmd.sel == 2'd2);
			if (mode_q == MODE_POS) begin
				out_q.out_x <= c_q[cmd.sel][0];
				out_q.out_y <= c_q[cmd.sel][1];
				out_q.out_z <= c_q[cmd.sel][2];
			end else begin
				out_q.out_x <= res_q[0];
				out_q.out_y <= res_q[1];
				out_q.out_z <= res_q[2];
			end
		end
	end

	assign out_data = out_q;

endmodule

@@ hw/rtl/fscb_ctrl.sv @@
module fscb_ctrl import fscb_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_mode,
	input  logic       out_ready,
	input  fscb_stat_t st,
	output logic       in_ready,
	output logic       out_valid,
	output fscb_cmd_t  cmd
);

	localparam logic [4:0] DIV_LAST = 5'(FRAC_BITS);

	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_DOT    = 14'b00000000000010,
		S_DRAIN  = 14'b00000000000100,
		S_CMP    = 14'b00000000001000,
		S_SUM    = 14'b00000000010000,
		S_NORM   = 14'b00000000100000,
		S_SQ     = 14'b00000001000000,
		S_ROOT   = 14'b00000010000000,
		S_DINIT  = 14'b00000100000000,
		S_DSTEP  = 14'b00001000000000,
		S_DSTORE = 14'b00010000000000,
		S_LERP   = 14'b00100000000000,
		S_LOAD   = 14'b01000000000000,
		S_EMIT   = 14'b10000000000000
	} fscb_state_t;

	fscb_state_t state_q, state_d;
	logic [4:0]  cnt_q, cnt_d;
	logic [1:0]  sel_q, sel_d;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		sel_d     = sel_q;
		cmd       = '0;
		cmd.idx   = cnt_q;
		cmd.sel   = sel_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					sel_d    = '0;
					state_d  = (in_mode == MODE_POS) ? S_DOT : S_SUM;
				end
			end
			S_DOT: begin
				cmd.dot = 1'b1;
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == 5'd8) state_d = S_DRAIN;
			end
			S_DRAIN: state_d = S_CMP;
			S_CMP: begin
				cmd.cmp = 1'b1;
				state_d = S_LOAD;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_NORM;
			end
			S_NORM: begin
				cnt_d = '0;
				if (st.mx_zero) begin
					state_d = S_LERP;
				end else if (st.mx_high || st.mx_low) begin
					cmd.norm = 1'b1;
				end else begin
					state_d = S_SQ;
				end
			end
			S_SQ: begin
				cmd.sq  = 1'b1;
				cmd.sel = cnt_q[1:0];
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == 5'd2) begin
					cnt_d   = '0;
					state_d = S_ROOT;
				end
			end
			S_ROOT: begin
				cmd.root = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q == 5'd31) state_d = S_DINIT;
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				state_d      = S_DSTEP;
			end
			S_DSTEP: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) state_d = S_DSTORE;
			end
			S_DSTORE: begin
				cmd.div_store = 1'b1;
				cnt_d         = '0;
				if (sel_q == 2'd2) begin
					sel_d   = '0;
					state_d = S_LERP;
				end else begin
					sel_d   = sel_q + 1'b1;
					state_d = S_DINIT;
				end
			end
			S_LERP: begin
				cmd.lerp = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q == 5'd2) state_d = S_LOAD;
			end
			S_LOAD: begin
				cmd.out_load = 1'b1;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cnt_d = '0;
					if (sel_q == 2'd2) begin
						cmd.face_inc = (st.mode == MODE_BITAN);
						state_d      = S_IDLE;
					end else begin
						sel_d   = sel_q + 1'b1;
						state_d = (st.mode == MODE_POS) ? S_LOAD : S_LERP;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			sel_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sel_q   <= sel_d;
		end
	end

endmodule

@@ hw/rtl/flat_shading_corner_blend_top.sv @@
// channel   dir  handshake           payload
// in_ch     in   valid/ready         mode, c1_x..c3_z (signed Q16.16)
// out_ch    out  valid/ready         kind, vertex_index, out_x/y/z, last
// cfg       in   cfg_we              cfg_data = shade_flat (Q1.16, 17 bits)
//
// One item at a time; each item gives three results in turn.
// Position item: dot products, a drain and a compare, then load and emit
// per result. Attribute item: sum, normalize shifts (0..29), squares, 32 root
// steps, a divide per component, then lerp/load/emit per result; a zero sum
// skips the root and divides. The root is bit-serial, the divider restoring.
// Reset: weights all one, face counter and shade_flat zero, no item held.
// A stalled result holds in the output register; no input is taken until
// the third result of the item leaves.
module flat_shading_corner_blend_top import fscb_pkg::*; #(
	parameter int MAX_FACES = MAX_FACES_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	fscb_in_if.sink         in_ch,
	fscb_out_if.source      out_ch,
	input  logic            cfg_we,
	input  logic [SF_W-1:0] cfg_data
);

	fscb_cmd_t  cmd;
	fscb_stat_t st;

	fscb_ctrl #(
		.FRAC_BITS (FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_mode   (in_ch.data.mode),
		.out_ready (out_ch.ready),
		.st        (st),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.cmd       (cmd)
	);

	fscb_dp #(
		.MAX_FACES (MAX_FACES),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_ch.data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.st       (st),
		.out_data (out_ch.data)
	);

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
	import fscb_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [SF_W-1:0] cfg_data = '0;

	fscb_in_if  in_ch ();
	fscb_out_if out_ch ();

	flat_shading_corner_blend_top dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	logic [SF_W-1:0] blend_amt;
	logic [2:0]      weight_mask;
	logic [19:0]     face_num;

	fscb_out_t corner_q[$];
	int errors = 0;
	bit long_hold = 1'b0;

	typedef struct {
		fscb_in_t item;
		bit       has_exp;
		fscb_out_t exp0;
	} row_t;

	function automatic longint mag64(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint mul_fix(longint d, longint e);
		longint unsigned p;
		p = (unsigned'(mag64(d)) * unsigned'(mag64(e))) >> FRAC_BITS_DEF;
		return ((d < 0) != (e < 0)) ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint root_floor(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void to_unit(input longint v[3], output longint o[3]);
		longint unsigned m[3], mx, sum, len, q;
		int dn, up;
		for (int k = 0; k < 3; k++) m[k] = mag64(v[k]);
		mx = m[0];
		if (m[1] > mx) mx = m[1];
		if (m[2] > mx) mx = m[2];
		if (mx == 0) begin
			o = v;
			return;
		end
		dn = 0;
		up = 0;
		sum = 0;
		while (mx >= (64'd1 << 30)) begin mx >>= 1; dn++; end
		while (mx < (64'd1 << 29)) begin mx <<= 1; up++; end
		for (int k = 0; k < 3; k++) begin
			m[k] = (m[k] >> dn) << up;
			sum += m[k] * m[k];
		end
		len = root_floor(sum);
		for (int k = 0; k < 3; k++) begin
			q = (m[k] * 64'd65536 + len / 2) / len;
			o[k] = v[k] < 0 ? -longint'(q) : longint'(q);
		end
	endfunction

	function automatic longint blend_one(longint a, longint n, longint sf);
		longint d, r;
		d = n - a;
		r = (mag64(d) * sf + 32768) >>> 16;
		return a + (d < 0 ? -r : r);
	endfunction

	function automatic void predict_corners(fscb_in_t it);
		longint c[3][3], s[3], n[3], r[3], e21[3], e31[3], e32[3], a1, a2, a3, sf, one, near;
		fscb_out_t o;
		c[0] = '{it.c1_x, it.c1_y, it.c1_z};
		c[1] = '{it.c2_x, it.c2_y, it.c2_z};
		c[2] = '{it.c3_x, it.c3_y, it.c3_z};
		one = 65536;
		near = 13107;
		sf = blend_amt > SF_ONE ? SF_ONE : blend_amt;
		s = '{0, 0, 0};
		if (it.mode != MODE_POS) begin
			for (int i = 0; i < 3; i++)
				if (weight_mask[i])
					for (int j = 0; j < 3; j++) s[j] += c[i][j];
			to_unit(s, n);
		end
		for (int i = 0; i < 3; i++) begin
			o.kind = it.mode;
			o.vertex_index = 22'(face_num * 3 + i);
			o.last = (i == 2);
			if (it.mode == MODE_POS) r = c[i];
			else for (int j = 0; j < 3; j++) r[j] = blend_one(c[i][j], n[j], sf);
			o.out_x = r[0][31:0];
			o.out_y = r[1][31:0];
			o.out_z = r[2][31:0];
			corner_q.push_back(o);
		end
		if (it.mode == MODE_POS) begin
			for (int j = 0; j < 3; j++) begin
				e21[j] = c[1][j] - c[0][j];
				e31[j] = c[2][j] - c[0][j];
				e32[j] = c[2][j] - c[1][j];
			end
			a1 = 0; a2 = 0; a3 = 0;
			for (int j = 0; j < 3; j++) begin
				a1 += mul_fix(e21[j], e31[j]);
				a2 += mul_fix(-e21[j], e32[j]);
				a3 += mul_fix(-e31[j], -e31[j]);
			end
			if (mag64(a1 - one) < near) weight_mask = MASK_NO1;
			else if (mag64(a2 - one) < near) weight_mask = MASK_NO2;
			else if (mag64(a3 - one) < near) weight_mask = MASK_NO3;
			else weight_mask = MASK_ALL;
		end else if (it.mode == MODE_BITAN) begin
			face_num = (face_num + 1 >= MAX_FACES_DEF) ? 0 : face_num + 1;
		end
	endfunction

	function automatic logic [31:0] rnd_comp();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'h7FFFFFFF;
			2: return 32'h80000000;
			3: return 32'(int'($urandom_range(0, 131072)) - 65536);
			default: return 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
		endcase
	endfunction

	function automatic fscb_in_t rnd_item(logic [1:0] m);
		fscb_in_t it;
		it.mode = m;
		it.c1_x = rnd_comp(); it.c1_y = rnd_comp(); it.c1_z = rnd_comp();
		it.c2_x = rnd_comp(); it.c2_y = rnd_comp(); it.c2_z = rnd_comp();
		it.c3_x = rnd_comp(); it.c3_y = rnd_comp(); it.c3_z = rnd_comp();
		if (m == MODE_POS && $urandom_range(0, 2) == 0) begin
			it.c1_x = 0; it.c1_y = 0; it.c1_z = 0;
			it.c2_x = 32'(int'($urandom_range(60000, 71000)));
			it.c2_y = 0; it.c2_z = 0;
			it.c3_x = $urandom_range(0, 1) ? 32'd0 : 32'(int'($urandom_range(60000, 71000)));
			it.c3_y = 32'(int'($urandom_range(60000, 71000)));
			it.c3_z = 0;
		end
		return it;
	endfunction

	task automatic send_item(fscb_in_t it);
		in_ch.data = it;
		in_ch.valid = 1'b1;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_corners(it);
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	task automatic drain_all();
		while (corner_q.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_blend(logic [SF_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		blend_amt = v;
	endtask

	always @(posedge clk) begin
		fscb_out_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (corner_q.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
			end else begin
				want = corner_q.pop_front();
				if (got.kind != want.kind) begin
					$display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind);
					errors++;
				end
				if (got.vertex_index != want.vertex_index) begin
					$display("%0t: vertex_index exp %0d got %0d", $time,
						want.vertex_index, got.vertex_index);
					errors++;
				end
				if (got.out_x != want.out_x) begin
					$display("%0t: out_x exp %h got %h", $time, want.out_x, got.out_x);
					errors++;
				end
				if (got.out_y != want.out_y) begin
					$display("%0t: out_y exp %h got %h", $time, want.out_y, got.out_y);
					errors++;
				end
				if (got.out_z != want.out_z) begin
					$display("%0t: out_z exp %h got %h", $time, want.out_z, got.out_z);
					errors++;
				end
				if (got.last != want.last) begin
					$display("%0t: last exp %0d got %0d", $time, want.last, got.last);
					errors++;
				end
			end
		end
	end

	initial begin
		int hold;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ch.ready <= 1'b0;
				for (hold = 0; hold < 400; hold++) @(negedge clk);
				long_hold = 1'b0;
			end
			if ($urandom_range(0, 40) == 0) begin
				out_ch.ready <= 1'b1;
				repeat ($urandom_range(20, 80)) @(negedge clk);
			end else begin
				case ($urandom_range(0, 3))
					0: out_ch.ready <= 1'b0;
					default: out_ch.ready <= 1'b1;
				endcase
			end
		end
	end

	initial begin
		#50ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		row_t rows[$];
		row_t rw;
		fscb_out_t e;
		fscb_in_t it;
		logic [SF_W-1:0] sets[6];
		int burst;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		blend_amt = '0;
		weight_mask = MASK_ALL;
		face_num = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		rw.item = '{mode: 2'd1, default: 32'sd0};
		rw.has_exp = 1'b1;
		e = '{kind: 2'd1, vertex_index: 22'd0, out_x: 0, out_y: 0, out_z: 0, last: 1'b0};
		rw.exp0 = e;
		rows.push_back(rw);
		rw.item = '{mode: MODE_POS, default: 32'h7FFFFFFF};
		rw.has_exp = 1'b1;
		e = '{kind: MODE_POS, vertex_index: 22'd0, out_x: 32'h7FFFFFFF,
			out_y: 32'h7FFFFFFF, out_z: 32'h7FFFFFFF, last: 1'b0};
		rw.exp0 = e;
		rows.push_back(rw);
		rw.has_exp = 1'b0;
		rw.item = '{mode: MODE_POS, default: 32'h80000000};
		rows.push_back(rw);
		rw.item = '{mode: MODE_POS, c1_x: 0, c1_y: 0, c1_z: 0, c2_x: 65536, c2_y: 0, c2_z: 0,
			c3_x: 0, c3_y: 65536, c3_z: 0};
		rows.push_back(rw);
		for (int m = 1; m < 4; m++) begin
			rw.item = rnd_item(2'(m));
			rows.push_back(rw);
		end
		rw.item = '{mode: MODE_POS, c1_x: 0, c1_y: 0, c1_z: 0, c2_x: 65536, c2_y: 0, c2_z: 0,
			c3_x: 65536, c3_y: 65536, c3_z: 0};
		rows.push_back(rw);
		rw.item = '{mode: 2'd2, default: 32'h80000000};
		rows.push_back(rw);
		rw.item = '{mode: MODE_POS, c1_x: 0, c1_y: 0, c1_z: 0, c2_x: 65536, c2_y: 0, c2_z: 0,
			c3_x: 0, c3_y: 32768, c3_z: 0};
		rows.push_back(rw);
		rw.item = '{mode: MODE_BITAN, default: 32'h7FFFFFFF};
		rows.push_back(rw);
		rw.item = '{mode: 2'd1, c1_x: 32'h80000000, c1_y: 0, c1_z: 0,
			c2_x: 32'h80000000, c2_y: 0, c2_z: 0, c3_x: 32'h80000000, c3_y: 0, c3_z: 0};
		rows.push_back(rw);

		foreach (rows[i]) begin
			if (i == 4) begin
				drain_all();
				write_blend(SF_ONE);
			end
			if (i == 10) begin
				drain_all();
				write_blend(17'h1FFFF);
			end
			if (rows[i].has_exp) begin
				predict_corners(rows[i].item);
				e = corner_q[corner_q.size() - 3];
				if (e != rows[i].exp0) begin
					$display("%0t: table row %0d exp %p pred %p", $time, i,
						rows[i].exp0, e);
					errors++;
				end
				void'(corner_q.pop_back()); void'(corner_q.pop_back()); void'(corner_q.pop_back());
				if (rows[i].item.mode == MODE_POS) weight_mask = MASK_ALL;
			end
			send_item(rows[i].item);
		end

		sets = '{17'd0, 17'd32768, SF_ONE, 17'd1, 17'd65535, 17'h1FFFF};
		for (int ph = 0; ph < 6; ph++) begin
			drain_all();
			write_blend(ph == 3 ? 17'($urandom_range(0, 131071)) : sets[ph]);
			if (ph == 2) long_hold = 1'b1;
			for (int f = 0; f < 15; f++) begin
				burst = $urandom_range(0, 3);
				if (burst == 0) repeat ($urandom_range(1, 60)) @(negedge clk);
				if ($urandom_range(0, 5) == 0) begin
					send_item(rnd_item(2'($urandom)));
				end else begin
					for (int m = 0; m < 4; m++) send_item(rnd_item(2'(m)));
				end
			end
		end

		drain_all();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

@@ flat_shading_corner_blend_top.f @@
hw/rtl/fscb_pkg.sv
hw/rtl/fscb_if.sv
hw/rtl/fscb_dp.sv
hw/rtl/fscb_ctrl.sv
hw/rtl/flat_shading_corner_blend_top.sv
tb/sv/tb_top.sv
